@@ src/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// mse_pkg
// shared types and constants for the merge sort engine
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int MSE_MAX_ITEMS = 64;
  localparam int VALUE_W       = 32;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_MERGE,
    ST_EMIT
  } mse_state_t;

  typedef struct packed {
    logic load;
    logic start_sort;
    logic pass_init;
    logic merge_step;
    logic emit_step;
    logic finish;
  } mse_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic pass_end;
    logic emit_last;
  } mse_sts_t;

endpackage

@@ src/mse_ram.sv @@
// ----------------------------------------------------------------------------
// mse_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ src/mse_ctrl.sv @@
// ----------------------------------------------------------------------------
// mse_ctrl
// sequencer for load, merge passes and emit
// ----------------------------------------------------------------------------
module mse_ctrl import mse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output mse_cmd_t cmd,
  input  mse_sts_t sts
);

  mse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            cmd.start_sort = 1'b1;
            state_nxt      = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.pass_init = 1'b1;
        state_nxt     = sts.sort_done ? ST_EMIT : ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge_step = 1'b1;
        if (sts.pass_end) begin
          state_nxt = ST_PREP;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.emit_last) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_LOAD;
          end else begin
            cmd.emit_step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

@@ src/mse_datapath.sv @@
// ----------------------------------------------------------------------------
// mse_datapath
// ping-pong buffers, run pointers and the merge compare
// ----------------------------------------------------------------------------
module mse_datapath import mse_pkg::*; #(
  parameter int MAX_ITEMS = MSE_MAX_ITEMS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mse_cmd_t           cmd,
  output mse_sts_t           sts,
  input  logic [VALUE_W-1:0] in_value,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last,
  output logic               out_dropped
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int W_W    = CNT_W + 1;
  localparam int SUM_W  = CNT_W + 2;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ITEMS);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             overflow_r, overflow_nxt;
  logic [W_W-1:0]   w_r, w_nxt;
  logic             src_sel_r, src_sel_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt, hi_r, hi_nxt;

  logic [VALUE_W-1:0] a_rd_a, a_rd_b, b_rd_a, b_rd_b;
  logic [VALUE_W-1:0] src_a, src_b, merged;
  logic               take_left, run_end, store_ok;
  logic [SUM_W-1:0]   n_ext, w_ext, k_inc;
  logic [CNT_W-1:0]   init_mid, init_hi, next_mid, next_hi;

  function automatic logic [CNT_W-1:0] clip(input logic [SUM_W-1:0] v,
                                            input logic [CNT_W-1:0] n);
    return (v > SUM_W'(n)) ? n : v[CNT_W-1:0];
  endfunction

  assign src_a = src_sel_r ? b_rd_a : a_rd_a;
  assign src_b = src_sel_r ? b_rd_b : a_rd_b;

  assign n_ext    = SUM_W'(count_r);
  assign w_ext    = SUM_W'(w_r);
  assign k_inc    = SUM_W'(k_r) + SUM_W'(1);
  assign store_ok = count_r < CAP;

  assign take_left = (i_r < mid_r) &&
                     ((j_r >= hi_r) || ($signed(src_a) < $signed(src_b)));
  assign merged    = take_left ? src_a : src_b;
  assign run_end   = k_inc == SUM_W'(hi_r);

  assign init_mid = clip(w_ext, count_r);
  assign init_hi  = clip(w_ext << 1, count_r);
  assign next_mid = clip(SUM_W'(hi_r) + w_ext, count_r);
  assign next_hi  = clip(SUM_W'(hi_r) + (w_ext << 1), count_r);

  assign sts.sort_done = w_ext >= n_ext;
  assign sts.pass_end  = k_inc == n_ext;
  assign sts.emit_last = (SUM_W'(i_r) + SUM_W'(1)) == n_ext;

  assign out_value   = src_a;
  assign out_last    = sts.emit_last;
  assign out_dropped = overflow_r;

  always_comb begin
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    w_nxt        = w_r;
    src_sel_nxt  = src_sel_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    mid_nxt      = mid_r;
    hi_nxt       = hi_r;
    if (cmd.load) begin
      if (store_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        overflow_nxt = 1'b1;
      end
    end
    if (cmd.start_sort) begin
      w_nxt       = W_W'(1);
      src_sel_nxt = 1'b0;
    end
    if (cmd.pass_init) begin
      i_nxt   = '0;
      k_nxt   = '0;
      mid_nxt = init_mid;
      j_nxt   = init_mid;
      hi_nxt  = init_hi;
    end
    if (cmd.merge_step) begin
      k_nxt = k_inc[CNT_W-1:0];
      if (run_end) begin
        i_nxt   = hi_r;
        mid_nxt = next_mid;
        j_nxt   = next_mid;
        hi_nxt  = next_hi;
      end else if (take_left) begin
        i_nxt = i_r + CNT_W'(1);
      end else begin
        j_nxt = j_r + CNT_W'(1);
      end
      if (sts.pass_end) begin
        w_nxt       = w_r << 1;
        src_sel_nxt = ~src_sel_r;
      end
    end
    if (cmd.emit_step) begin
      i_nxt = i_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      count_nxt    = '0;
      overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
      w_r        <= '0;
      src_sel_r  <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      mid_r      <= '0;
      hi_r       <= '0;
    end else begin
      count_r    <= count_nxt;
      overflow_r <= overflow_nxt;
      w_r        <= w_nxt;
      src_sel_r  <= src_sel_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      mid_r      <= mid_nxt;
      hi_r       <= hi_nxt;
    end
  end

  // buffer a takes loads and even-numbered passes, buffer b the odd-numbered ones
  mse_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_buf_a (
    .clk     (clk),
    .we      ((cmd.load && store_ok) || (cmd.merge_step && src_sel_r)),
    .waddr   (cmd.load ? count_r[ADDR_W-1:0] : k_r[ADDR_W-1:0]),
    .wdata   (cmd.load ? in_value : merged),
    .raddr_a (i_nxt[ADDR_W-1:0]),
    .raddr_b (j_nxt[ADDR_W-1:0]),
    .rdata_a (a_rd_a),
    .rdata_b (a_rd_b)
  );

  mse_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_buf_b (
    .clk     (clk),
    .we      (cmd.merge_step && !src_sel_r),
    .waddr   (k_r[ADDR_W-1:0]),
    .wdata   (merged),
    .raddr_a (i_nxt[ADDR_W-1:0]),
    .raddr_b (j_nxt[ADDR_W-1:0]),
    .rdata_a (b_rd_a),
    .rdata_b (b_rd_b)
  );

  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("item count beyond capacity");

  a_merge_bounds : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> (k_r < count_r && i_r <= mid_r && j_r <= hi_r && hi_r <= count_r))
    else $error("merge pointers out of run");

  a_finish_clear : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (count_r == '0 && !overflow_r))
    else $error("set not cleared after final item");

endmodule

@@ src/merge_sort_engine_top.sv @@
// ----------------------------------------------------------------------------
// merge_sort_engine_top
// collects a set of signed values and returns it in ascending order
// ----------------------------------------------------------------------------
// input channel: one value per item; tlast closes the set. up to MAX_ITEMS
// values are kept, further ones are dropped and flag the whole set.
// in_tready is high only while collecting, one item per cycle.
// after the closing item the set of n values is sorted by bottom-up merge
// passes between two ping-pong buffers. each pass is a set-up step and then
// one merge step per value, with ceil(log2(n)) passes in all, followed by a
// final set-up step that finds the set sorted.
// output channel: the n values in order, one per cycle, tlast on the final
// one and tuser marking a set that lost items. a stall holds the current
// item in place; the next set is taken only once the final item has left.
// reset returns the block to collecting with an empty set; the buffers need
// no clearing.
// ----------------------------------------------------------------------------
module merge_sort_engine_top import mse_pkg::*; #(
  parameter int MAX_ITEMS = MSE_MAX_ITEMS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // sample_value
  input  logic               in_tlast,   // last_item
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // sorted_value
  output logic               out_tlast,  // last_result
  output logic [0:0]         out_tuser   // dropped
);

  mse_cmd_t cmd;
  mse_sts_t sts;
  logic     dropped;

  mse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mse_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_value    (in_tdata),
    .out_value   (out_tdata),
    .out_last    (out_tlast),
    .out_dropped (dropped)
  );

  assign out_tuser = dropped;

endmodule

@@ bench/merge_sort_engine_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine_top_tb
// self-checking bench for the merge sort engine
// ----------------------------------------------------------------------------
// sets of signed values are streamed in, each closed by tlast. a predictor
// collects every accepted item, drops those beyond capacity and sorts the set
// when it closes, queueing the sorted values with their tlast and dropped
// flags. each result leaving the block is checked against the oldest queued
// one. directed sets cover the value extremes, ties and a single-item set;
// random sets follow, among them a full set and one that overflows. both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module merge_sort_engine_top_tb import mse_pkg::*; ();

  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 500;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 40;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } sample_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               dropped;
  } sorted_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic [VALUE_W-1:0] in_tdata   = '0;
  logic               in_tlast   = 1'b0;
  logic               out_tready = 1'b0;
  logic               in_tready;
  logic               out_tvalid;
  logic [VALUE_W-1:0] out_tdata;
  logic               out_tlast;
  logic [0:0]         out_tuser;

  sample_t                   send_q[$];
  sorted_t                   expected_q[$];
  logic signed [VALUE_W-1:0] set_vals[$];
  logic                      set_overflow = 1'b0;

  int   errors       = 0;
  int   cycle_count  = 0;
  int   results_seen = 0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  logic send_burst   = 1'b0;
  logic recv_burst   = 1'b0;

  merge_sort_engine_top #(
    .MAX_ITEMS(MSE_MAX_ITEMS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  function void add_sample(input logic [VALUE_W-1:0] value, input logic last);
    sample_t s;
    s.value = value;
    s.last  = last;
    send_q.push_back(s);
  endfunction

  function void predict_sorted(input logic [VALUE_W-1:0] value, input logic last);
    logic signed [VALUE_W-1:0] key;
    sorted_t                   r;
    int                        i;
    int                        j;
    if (set_vals.size() < MSE_MAX_ITEMS) begin
      set_vals.push_back(value);
    end else begin
      set_overflow = 1'b1;
    end
    if (last) begin
      for (i = 1; i < set_vals.size(); i++) begin
        key = set_vals[i];
        j = i - 1;
        while (j >= 0 && set_vals[j] > key) begin
          set_vals[j + 1] = set_vals[j];
          j--;
        end
        set_vals[j + 1] = key;
      end
      for (i = 0; i < set_vals.size(); i++) begin
        r.value   = set_vals[i];
        r.last    = (i == set_vals.size() - 1);
        r.dropped = set_overflow;
        expected_q.push_back(r);
      end
      set_vals.delete();
      set_overflow = 1'b0;
    end
  endfunction

  // sender
  always @(posedge clk) begin : driver
    sample_t nxt;
    int      gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else begin
      gap = send_burst ? 0 : $urandom_range(0, 9);
      if (in_tvalid && in_tready) begin
        predict_sorted(in_tdata, in_tlast);
        if (in_tlast) send_burst <= ($urandom_range(0, 3) == 0);
        if (gap == 0 && send_q.size() > 0) begin
          nxt = send_q.pop_front();
          in_tdata  <= nxt.value;
          in_tlast  <= nxt.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
          gap_left  <= gap;
        end
      end else if (!in_tvalid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (send_q.size() > 0) begin
          nxt = send_q.pop_front();
          in_tdata  <= nxt.value;
          in_tlast  <= nxt.last;
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : monitor
    sorted_t want;
    int      wait_cycles;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: sorted_value %0d", $signed(out_tdata));
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata !== want.value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   $signed(want.value), $signed(out_tdata));
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last_result: expected %0b, actual %0b", want.last, out_tlast);
            errors++;
          end
          if (out_tuser[0] !== want.dropped) begin
            $error("dropped: expected %0b, actual %0b", want.dropped, out_tuser[0]);
            errors++;
          end
        end
        results_seen++;
        if (out_tlast) recv_burst = ($urandom_range(0, 3) == 0);
        if (results_seen == HOLD_AT) begin
          wait_cycles = LONG_HOLD;
        end else begin
          wait_cycles = recv_burst ? 0 : $urandom_range(0, 9);
        end
        if (wait_cycles == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          stall_left <= wait_cycles;
        end
      end else if (!out_tready) begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("merge_sort_engine_top_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] v;
    int                 s;
    int                 n;
    int                 k;
    int                 rand_items;

    // single-item set
    add_sample(32'h7fff_ffff, 1'b1);
    // value extremes
    add_sample(32'h8000_0000, 1'b0);
    add_sample(32'h7fff_ffff, 1'b0);
    add_sample(32'h0000_0000, 1'b0);
    add_sample(32'hffff_ffff, 1'b0);
    add_sample(32'h0000_0001, 1'b1);
    // ties
    add_sample(5, 1'b0);
    add_sample(-3, 1'b0);
    add_sample(5, 1'b0);
    add_sample(-3, 1'b0);
    add_sample(5, 1'b1);
    // two items, reversed
    add_sample(100, 1'b0);
    add_sample(-100, 1'b1);
    // descending run
    for (k = 0; k < 7; k++) add_sample(30 - 10 * k, k == 6);

    // random sets: mostly small, one exactly full, one losing its last two items, the closing one among them
    rand_items = 0;
    s = 0;
    while (rand_items < 140 || s < 4) begin
      if (s == 1) begin
        n = MSE_MAX_ITEMS;
      end else if (s == 3) begin
        n = MSE_MAX_ITEMS + 2;
      end else begin
        n = $urandom_range(1, 12);
      end
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 4))
          0: v = $urandom_range(0, 8) - 4;
          1: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
          default: v = $urandom;
        endcase
        add_sample(v, k == n - 1);
      end
      rand_items += n;
      s++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (send_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("merge_sort_engine_top_tb passed");
    end else begin
      $display("merge_sort_engine_top_tb failed");
    end
    $finish;
  end

endmodule
